// ===== rtl/core/gkm_pkg.sv =====
// Shared types, constants and the exp lookup table for the Gaussian kernel block.
// Used by gkm_front, gkm_queue, gkm_back and gaussian_kernel_matrix.
// No dependencies.
package gkm_pkg;

  // Store geometry
  localparam int MAX_POINTS = 1024;
  localparam int MAX_DIMS   = 16;
  localparam int ROW_W      = $clog2(MAX_POINTS);
  localparam int DIM_W      = $clog2(MAX_DIMS);
  localparam int DCNT_W     = $clog2(MAX_DIMS + 1);
  localparam int ADDR_W     = ROW_W + DIM_W;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + DCNT_W - 1;
  localparam int INV_W   = 24;
  localparam int KV_W    = 16;
  localparam int PC_W    = 11;
  localparam int DIMS_W  = 5;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  // Scale product split into two halves
  localparam int HALF_W  = (DIST_W + 1) / 2;
  localparam int PPROD_W = HALF_W + INV_W;
  localparam int FULL_W  = DIST_W + INV_W;

  // Exp table: Q1.32 entries at x = k/16
  localparam int EXP_STEPS = 256;
  localparam int EXP_IDX_W = $clog2(EXP_STEPS + 1);
  localparam int EXP_I_W   = $clog2(EXP_STEPS);
  localparam int FRAC_W    = 12;
  localparam int TAB_W     = 33;
  localparam int IPROD_W   = TAB_W + FRAC_W;
  localparam logic [63:0] EXP_STEP_MUL = 64'd4034748382;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Opcodes of the input item
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DIMS_IN_USE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_POINT_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_INV_SIGMA   = 2'd2;

  typedef struct packed {
    logic [DIMS_W-1:0] dims_in_use;
    logic [PC_W-1:0]   point_count;
    logic [INV_W-1:0]  inv_four_sigma_sq;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_QERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ROW_W-1:0]   row_a;
    logic [ROW_W-1:0]   row_b;
    logic [DIM_W-1:0]   dim;
    logic [COORD_W-1:0] coord;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_SCALE,
    BK_ADD,
    BK_INTERP,
    BK_ROUND,
    BK_POST
  } bk_state_t;

  typedef logic [EXP_STEPS:0][TAB_W-1:0] exp_tab_t;

  // T[0] = 2^32, T[k+1] = round(T[k] * exp(-1/16))
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] t;
    t      = 64'd1 << 32;
    tab[0] = t[TAB_W-1:0];
    for (int k = 0; k < EXP_STEPS; k++) begin
      t          = (t * EXP_STEP_MUL + 64'h8000_0000) >> 32;
      tab[k + 1] = t[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

// ===== rtl/core/gkm_front.sv =====
// Front end: accepts input items, checks query indices and classifies them.
// Depends on gkm_pkg; feeds gkm_queue.
module gkm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gkm_pkg::cfg_t               cfg,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,
  input  logic                        in_tuser,
  output logic                        push_valid,
  input  logic                        push_ready,
  output gkm_pkg::cmd_t               push_cmd
);
  import gkm_pkg::*;

  logic  fr_valid_r;
  cmd_t  fr_cmd_r;
  cmd_t  cls_cmd;
  logic  accept;
  logic  bad_idx;

  assign in_tready = !fr_valid_r || push_ready;
  assign accept    = in_tvalid && in_tready;

  // Unpack and classify; an index at or past point_count is an error
  always_comb begin
    cls_cmd.row_a = in_tdata[ROW_W-1:0];
    cls_cmd.row_b = in_tdata[2*ROW_W-1:ROW_W];
    cls_cmd.dim   = in_tdata[2*ROW_W+DIM_W-1:2*ROW_W];
    cls_cmd.coord = in_tdata[2*ROW_W+DIM_W+COORD_W-1:2*ROW_W+DIM_W];
    bad_idx = ({1'b0, cls_cmd.row_a} >= cfg.point_count) ||
              ({1'b0, cls_cmd.row_b} >= cfg.point_count);
    if (in_tuser == OP_LOAD) begin
      cls_cmd.kind = CMD_LOAD;
    end else if (bad_idx) begin
      cls_cmd.kind = CMD_QERR;
    end else begin
      cls_cmd.kind = CMD_QUERY;
    end
  end

  // Holding register toward the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= cls_cmd;
    end
  end

  assign push_valid = fr_valid_r;
  assign push_cmd   = fr_cmd_r;

endmodule

// ===== rtl/core/gkm_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on gkm_pkg.
module gkm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gkm_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gkm_pkg::cmd_t pop_cmd
);
  import gkm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/core/gkm_back.sv =====
// Back end: point store, squared distance accumulation, scaling, exp lookup
// and the output register. Depends on gkm_pkg; fed by gkm_queue.
module gkm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gkm_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  gkm_pkg::cmd_t pop_cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic          out_tuser
);
  import gkm_pkg::*;

  // Point store: one coordinate per entry, two read ports
  logic [COORD_W-1:0] store_mem [1 << ADDR_W];

  bk_state_t          state_r, state_nxt;
  logic [ROW_W-1:0]   qa_r, qb_r;
  logic [DCNT_W-1:0]  issue_cnt_r;
  logic [DCNT_W-1:0]  dims_eff;
  logic [COORD_W-1:0] rd_a_r, rd_b_r;
  logic               rd_v_r, sq_v_r;
  logic [SQ_W-1:0]    sq_r;
  logic [DIST_W-1:0]  acc_r;
  logic [PPROD_W-1:0] prod_hi_r, prod_lo_r;
  logic               big_r;
  logic [EXP_I_W-1:0] ei_r;
  logic [FRAC_W-1:0]  ef_r;
  logic [TAB_W-1:0]   t0_r;
  logic [IPROD_W-1:0] dp_r;
  logic [KV_W-1:0]    res_kv_r;
  logic               res_err_r;
  logic               out_valid_r;
  logic [KV_W-1:0]    out_kv_r;
  logic               out_err_r;

  // FSM outputs
  logic               take;
  logic               mem_we;
  logic               issue;
  logic               start_sum;
  logic               set_err;
  logic               load_out;
  logic               out_free;
  logic               sum_done;

  // Datapath nets
  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]      diff_abs;
  logic [FULL_W-1:0]       full;
  logic [EXP_IDX_W-1:0]    ti0, ti1;
  logic [TAB_W-1:0]        t0, t1, tdiff;
  logic [TAB_W-1:0]        v;
  logic [TAB_W:0]          vr;
  logic [TAB_W-16:0]       vq;
  logic [KV_W-1:0]         kv;

  assign dims_eff = (cfg.dims_in_use > DIMS_W'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS)
                                                            : DCNT_W'(cfg.dims_in_use);
  assign out_free = !out_valid_r || out_tready;
  assign sum_done = (issue_cnt_r >= dims_eff) && !rd_v_r && !sq_v_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          unique case (pop_cmd.kind)
            CMD_QUERY: state_nxt = BK_SUM;
            CMD_QERR:  state_nxt = BK_POST;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_SUM:    if (sum_done) state_nxt = BK_SCALE;
      BK_SCALE:  state_nxt = BK_ADD;
      BK_ADD:    state_nxt = BK_INTERP;
      BK_INTERP: state_nxt = BK_ROUND;
      BK_ROUND:  state_nxt = BK_POST;
      BK_POST:   if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    pop_ready = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    start_sum = 1'b0;
    set_err   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          mem_we    = (pop_cmd.kind == CMD_LOAD);
          start_sum = (pop_cmd.kind == CMD_QUERY);
          set_err   = (pop_cmd.kind == CMD_QERR);
        end
      end
      BK_SUM:  issue    = (issue_cnt_r < dims_eff);
      BK_POST: load_out = out_free;
      default: ;
    endcase
  end
  assign take = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store write and paired coordinate reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[{pop_cmd.row_a, pop_cmd.dim}] <= pop_cmd.coord;
    end
    rd_a_r <= store_mem[{qa_r, issue_cnt_r[DIM_W-1:0]}];
    rd_b_r <= store_mem[{qb_r, issue_cnt_r[DIM_W-1:0]}];
  end

  // Read and square pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      sq_v_r <= rd_v_r;
    end
  end

  // Squared difference
  assign diff     = $signed({rd_a_r[COORD_W-1], rd_a_r}) - $signed({rd_b_r[COORD_W-1], rd_b_r});
  assign diff_abs = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

  always_ff @(posedge clk) begin
    sq_r <= diff_abs * diff_abs;
  end

  // Row latch, read counter and accumulator
  always_ff @(posedge clk) begin
    if (start_sum) begin
      qa_r        <= pop_cmd.row_a;
      qb_r        <= pop_cmd.row_b;
      issue_cnt_r <= '0;
      acc_r       <= '0;
    end else begin
      if (issue) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (sq_v_r) begin
        acc_r <= acc_r + DIST_W'(sq_r);
      end
    end
  end

  // Scale: two half products, then recombine and split into overflow flag, index and fraction
  assign full = (FULL_W'(prod_hi_r) << HALF_W) + FULL_W'(prod_lo_r);

  always_ff @(posedge clk) begin
    if (state_r == BK_SCALE) begin
      prod_hi_r <= PPROD_W'(acc_r[DIST_W-1:HALF_W]) * PPROD_W'(cfg.inv_four_sigma_sq);
      prod_lo_r <= PPROD_W'(acc_r[HALF_W-1:0]) * PPROD_W'(cfg.inv_four_sigma_sq);
    end
    if (state_r == BK_ADD) begin
      big_r <= |full[FULL_W-1:INV_W+FRAC_W+EXP_I_W];
      ei_r  <= full[INV_W+FRAC_W+EXP_I_W-1:INV_W+FRAC_W];
      ef_r  <= full[INV_W+FRAC_W-1:INV_W];
    end
  end

  // Table lookup and interpolation product
  assign ti0   = {1'b0, ei_r};
  assign ti1   = ti0 + 1'b1;
  assign t0    = EXP_TABLE[ti0];
  assign t1    = EXP_TABLE[ti1];
  assign tdiff = t0 - t1;

  always_ff @(posedge clk) begin
    if (state_r == BK_INTERP) begin
      t0_r <= t0;
      dp_r <= IPROD_W'(tdiff) * IPROD_W'(ef_r);
    end
  end

  // Round to Q0.16 and saturate
  assign v  = t0_r - dp_r[IPROD_W-1:FRAC_W];
  assign vr = {1'b0, v} + (TAB_W+1)'(32768);
  assign vq = vr[TAB_W:16];
  assign kv = (vq > (TAB_W-15)'(16'hFFFF)) ? 16'hFFFF : vq[KV_W-1:0];

  always_ff @(posedge clk) begin
    if (set_err) begin
      res_kv_r  <= '0;
      res_err_r <= 1'b1;
    end else if (state_r == BK_ROUND) begin
      res_kv_r  <= big_r ? '0 : kv;
      res_err_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kv_r  <= res_kv_r;
      out_err_r <= res_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_kv_r;
  assign out_tuser  = out_err_r;

  a_rd_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == BK_SUM))
    else $error("coordinate read outside accumulation");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SUM) |-> (issue_cnt_r <= DCNT_W'(MAX_DIMS)))
    else $error("read counter past dimension limit");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == BK_POST) && res_err_r) |-> (res_kv_r == '0))
    else $error("error result with nonzero kernel value");

  a_post_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == BK_POST) && out_valid_r && !out_tready) |=> (state_r == BK_POST))
    else $error("result dropped while output register full");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> ((state_r == BK_IDLE) || (state_r == BK_SUM) || (state_r == BK_POST)))
    else $error("unexpected state after taking a command");

endmodule

// ===== rtl/core/gaussian_kernel_matrix.sv =====
// Top level of the Gaussian RBF kernel unit: configuration registers and the
// front end, command queue and back end. Depends on gkm_pkg, gkm_front,
// gkm_queue and gkm_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in_     | in        | in_tvalid/in_tready  | tdata row_a,row_b,dim_index,coord
//   out_    | out       | out_tvalid/out_tready| tdata kernel_value, tuser error
//   cfg_    | in        | cfg_we               | cfg_index, cfg_wdata
//
// A load is written to the store as the back end takes it. A query runs in the
// back end through the take, one coordinate pair per cycle from the two-port
// store, a drain of reads and squares, four exp steps and one handoff. A range
// error goes from the take straight to the handoff.
// Reset is synchronous; config returns to 1, 1 and 1.0, the store is unset.
// The front and back are parted by a two-entry queue; the output register
// lets the back end take the next item while a result waits.
module gaussian_kernel_matrix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,   // row_a[9:0], row_b[19:10],
                                                   // dim_index[23:20], coord_value[39:24]
  input  logic                         in_tuser,   // op
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // kernel_value[15:0]
  output logic                         out_tuser,  // range_error
  input  logic                         cfg_we,
  input  logic [gkm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [gkm_pkg::CFG_W-1:0]    cfg_wdata
);
  import gkm_pkg::*;

  cfg_t cfg_r;
  logic q_push_valid, q_push_ready;
  cmd_t q_push_cmd;
  logic q_pop_valid, q_pop_ready;
  cmd_t q_pop_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dims_in_use       <= DIMS_W'(1);
      cfg_r.point_count       <= PC_W'(1);
      cfg_r.inv_four_sigma_sq <= INV_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIMS_IN_USE: cfg_r.dims_in_use       <= cfg_wdata[DIMS_W-1:0];
        CFG_POINT_COUNT: cfg_r.point_count       <= cfg_wdata[PC_W-1:0];
        CFG_INV_SIGMA:   cfg_r.inv_four_sigma_sq <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  gkm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  gkm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  gkm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
